// ----- hw/rtl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner: transaction
// payloads, operation codes and the internal control bundles.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int DATA_W         = 8;
    localparam int ENTRY_IDX_W    = 6;
    localparam int ENTRY_SLOTS    = 64;
    localparam int CFG_LEN_W      = 7;
    localparam int MATCH_OFFSET_W = 32;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                   operation;
        logic [DATA_W-1:0]      data_byte;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic                   care;
        logic                   last_byte;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } out_item_t;

    // Pattern entry write
    typedef struct packed {
        logic                   en;
        logic [ENTRY_IDX_W-1:0] index;
        logic [DATA_W-1:0]      data;
        logic                   care;
    } pat_wr_t;

    // Window shift request
    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] data;
    } win_ctrl_t;

endpackage

// ----- hw/rtl/mbps_pattern_regs.sv -----
// ----------------------------------------------------------------------------
// mbps_pattern_regs
// Pattern entry storage: one byte and one care bit per entry, written one
// entry at a time, every entry visible at once for the parallel compare.
// ----------------------------------------------------------------------------
module mbps_pattern_regs #(
    parameter int LANES = 64
) (
    input  logic                                aclk,
    input  mbps_pkg::pat_wr_t                   wr,
    output logic [LANES*mbps_pkg::DATA_W-1:0]   pat_flat,
    output logic [LANES-1:0]                    care_vec
);

    localparam int DataW = mbps_pkg::DATA_W;

    logic [DataW-1:0] pat_reg  [LANES];
    logic             care_reg [LANES];

    // Write one entry; contents are undefined until loaded
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (wr.en && (int'(wr.index) == i)) begin
                pat_reg[i]  <= wr.data;
                care_reg[i] <= wr.care;
            end
        end
    end

    // Flatten for the compare lanes
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            pat_flat[i*DataW +: DataW] = pat_reg[i];
            care_vec[i]                = care_reg[i];
        end
    end

endmodule

// ----- hw/rtl/mbps_match_unit.sv -----
// ----------------------------------------------------------------------------
// mbps_match_unit
// Region byte window and masked compare. The window holds the newest bytes,
// newest at slot 0. The updated window is aligned to the pattern by a byte
// barrel shift and compared lane by lane against the cared-for entries.
// ----------------------------------------------------------------------------
module mbps_match_unit #(
    parameter int LANES = 64,
    parameter int LEN_W = 7
) (
    input  logic                                aclk,
    input  mbps_pkg::win_ctrl_t                 ctrl,
    input  logic [LEN_W-1:0]                    len,
    input  logic [LANES*mbps_pkg::DATA_W-1:0]   pat_flat,
    input  logic [LANES-1:0]                    care_vec,
    output logic                                window_hit
);

    localparam int DataW = mbps_pkg::DATA_W;
    localparam int FlatW = LANES * DataW;

    logic [DataW-1:0] win_reg [LANES];
    logic [FlatW-1:0] new_flat;
    logic [FlatW-1:0] rev_flat;
    logic [FlatW-1:0] aligned_flat;
    logic [LEN_W-1:0] shamt;
    logic [LANES-1:0] lane_ok;

    // Shift the region byte in; stale slots are never compared because the
    // byte count gates the hit
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg[0] <= ctrl.data;
            for (int i = 1; i < LANES; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Build the window as it stands after this byte, plus its byte reversal
    always_comb begin
        new_flat[0 +: DataW] = ctrl.data;
        for (int i = 1; i < LANES; i++) begin
            new_flat[i*DataW +: DataW] = win_reg[i-1];
        end
        for (int i = 0; i < LANES; i++) begin
            rev_flat[i*DataW +: DataW] = new_flat[(LANES-1-i)*DataW +: DataW];
        end
    end

    // Align so that lane j holds the byte that pattern entry j must match
    assign shamt        = LEN_W'(LANES) - len;
    assign aligned_flat = rev_flat >> {shamt, 3'b000};

    // Compare every lane; lanes past the length and wildcards always pass
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            lane_ok[j] = (LEN_W'(j) >= len) || !care_vec[j] ||
                         (aligned_flat[j*DataW +: DataW] == pat_flat[j*DataW +: DataW]);
        end
    end

    assign window_hit = &lane_ok;

endmodule

// ----- hw/rtl/masked_byte_pattern_scanner_top.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Masked byte pattern scanner: loads pattern entries with care bits, scans a
// region byte stream and reports the first match offset or not-found.
//
//   Port group   Dir   Handshake          Payload
//   s_*          in    s_valid/s_ready    mbps_pkg::in_item_t  (load or scan)
//   m_*          out   m_valid/m_ready    mbps_pkg::out_item_t (found, offset)
//   cfg_*        in    cfg_we             cfg_wdata: pattern length
//
// One transaction per cycle sustained while results are taken. A transaction is
// captured in the input register and evaluated from there; its result is then
// registered in the result register and driven on m_*. The window compare, the
// byte count and the result register all advance together, so one item moves per
// cycle while the result register can take a new result. A held result stalls
// the input register, and s_ready drops once both are full. Reset is synchronous,
// active low; it clears the region state and sets the pattern length to one.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbps_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbps_pkg::out_item_t                 m_item,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_LEN_W-1:0]      cfg_wdata
);

    localparam int Lanes  = (PATTERN_MAX < mbps_pkg::ENTRY_SLOTS) ?
                            PATTERN_MAX : mbps_pkg::ENTRY_SLOTS;
    localparam int LenW   = $clog2(Lanes + 1);
    localparam int CountW = OFFSET_BITS + 1;
    localparam int OutW   = mbps_pkg::MATCH_OFFSET_W;
    localparam int DataW  = mbps_pkg::DATA_W;

    logic [mbps_pkg::CFG_LEN_W-1:0] len_cfg_reg;
    logic [LenW-1:0]                len_eff;

    logic                           in_valid_reg;
    mbps_pkg::in_item_t             in_item_reg;
    logic                           advance;

    logic [CountW-1:0]              bytes_seen_reg, bytes_seen_next;
    logic                           reported_reg, reported_next;
    logic [CountW-1:0]              count_inc;
    logic [CountW-1:0]              offset;
    logic                           is_scan, do_scan, full, scan_hit, emit;

    logic                           out_valid_reg;
    mbps_pkg::out_item_t            out_item_reg;

    mbps_pkg::pat_wr_t              pat_wr;
    mbps_pkg::win_ctrl_t            win_ctrl;
    logic [Lanes*DataW-1:0]         pat_flat;
    logic [Lanes-1:0]               care_vec;
    logic                           window_hit;

    // Length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= mbps_pkg::CFG_LEN_W'(1);
        end else if (cfg_we) begin
            len_cfg_reg <= cfg_wdata;
        end
    end

    // Clamp the length to one through the lane count
    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = LenW'(1);
        end else if (int'(len_cfg_reg) > Lanes) begin
            len_eff = LenW'(Lanes);
        end else begin
            len_eff = LenW'(len_cfg_reg);
        end
    end

    // Input register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Pattern store and window compare
    always_comb begin
        pat_wr.en     = advance && (in_item_reg.operation == mbps_pkg::OP_LOAD) &&
                        (int'(in_item_reg.entry_index) < Lanes);
        pat_wr.index  = in_item_reg.entry_index;
        pat_wr.data   = in_item_reg.data_byte;
        pat_wr.care   = in_item_reg.care;
        win_ctrl.shift = advance && do_scan;
        win_ctrl.data  = in_item_reg.data_byte;
    end

    mbps_pattern_regs #(
        .LANES (Lanes)
    ) u_pattern_regs (
        .aclk     (aclk),
        .wr       (pat_wr),
        .pat_flat (pat_flat),
        .care_vec (care_vec)
    );

    mbps_match_unit #(
        .LANES (Lanes),
        .LEN_W (LenW)
    ) u_match_unit (
        .aclk       (aclk),
        .ctrl       (win_ctrl),
        .len        (len_eff),
        .pat_flat   (pat_flat),
        .care_vec   (care_vec),
        .window_hit (window_hit)
    );

    // Count, hit decision and region state
    always_comb begin
        is_scan   = (in_item_reg.operation == mbps_pkg::OP_SCAN);
        do_scan   = is_scan && !reported_reg;
        count_inc = (bytes_seen_reg == '1) ? bytes_seen_reg :
                                            bytes_seen_reg + CountW'(1);
        full      = (count_inc >= CountW'(len_eff));
        offset    = count_inc - CountW'(len_eff);
        scan_hit  = do_scan && full && window_hit && !offset[CountW-1];
        emit      = scan_hit || (do_scan && in_item_reg.last_byte);

        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        if (is_scan && in_item_reg.last_byte) begin
            bytes_seen_next = '0;
            reported_next   = 1'b0;
        end else if (do_scan) begin
            bytes_seen_next = count_inc;
            reported_next   = scan_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end else if (advance) begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_item_reg.found        <= scan_hit;
            out_item_reg.match_offset <= scan_hit ? OutW'(offset) : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // A reported match blocks further results until the region ends
    a_hit_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && scan_hit && !in_item_reg.last_byte |=> reported_reg)
        else $error("match did not set the reported flag");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_scan && in_item_reg.last_byte |=>
            (bytes_seen_reg == '0) && !reported_reg)
        else $error("last byte did not clear region state");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("held result overwritten");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_item_reg.found |-> out_item_reg.match_offset == '0)
        else $error("not-found result with nonzero offset");

    a_flag_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg && advance |=> $stable(bytes_seen_reg) || (bytes_seen_reg == '0))
        else $error("count moved after a reported match");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked byte pattern scanner. A queue-fed driver
// pushes pattern loads and region bytes through the input handshake. A
// scoreboard model of the pattern, window and byte count predicts each
// match or not-found report, and a monitor compares every report field by
// field. The bench runs a short directed sequence and then random phases.
// Each phase sets a new pattern length (including out-of-range values) and
// streams mostly planted matches, plus broken, short and noisy regions.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH     = 64;
    localparam int ITEM_TARGET   = 1200;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 40;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    mbps_pkg::in_item_t             s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    mbps_pkg::out_item_t            m_item;
    logic                           cfg_we    = 1'b0;
    logic [mbps_pkg::CFG_LEN_W-1:0] cfg_wdata = '0;

    // Transactions waiting for the driver, reports owed by the scanner
    mbps_pkg::in_item_t  pending_items[$];
    mbps_pkg::out_item_t owed_reports[$];

    int mismatches = 0;
    int stim_count = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int gap_left   = 0;
    int stall_left = 0;

    // Scoreboard copy of the scanner state
    bit [mbps_pkg::DATA_W-1:0]    pat_mem  [mbps_pkg::ENTRY_SLOTS];
    bit                           care_mem [mbps_pkg::ENTRY_SLOTS];
    bit [mbps_pkg::DATA_W-1:0]    win_bytes[WIN_DEPTH];
    bit [32:0]                    seen_count = '0;
    bit                           hit_sent   = 1'b0;
    bit [mbps_pkg::CFG_LEN_W-1:0] length_reg = 1;

    // Pattern as the stimulus generator has queued it
    bit [mbps_pkg::DATA_W-1:0] gen_pat  [mbps_pkg::ENTRY_SLOTS];
    bit                        gen_care [mbps_pkg::ENTRY_SLOTS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    masked_byte_pattern_scanner_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clamp the length register to the span the window supports
    function automatic int active_len(input bit [mbps_pkg::CFG_LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > WIN_DEPTH) return WIN_DEPTH;
        return int'(v);
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTS) $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Advance the scoreboard model by one accepted transaction
    task automatic advance_scanner(input mbps_pkg::in_item_t it);
        int                  len;
        bit                  hit;
        bit [32:0]           off;
        mbps_pkg::out_item_t rep;
        if (it.operation == mbps_pkg::OP_LOAD) begin
            // every 6-bit index addresses a real entry
            pat_mem[it.entry_index]  = it.data_byte;
            care_mem[it.entry_index] = it.care;
            return;
        end
        if (!hit_sent) begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = it.data_byte;
            if (seen_count != '1) seen_count++;
            len = active_len(length_reg);
            hit = 1'b0;
            off = '0;
            if (seen_count >= len) begin
                hit = 1'b1;
                for (int j = 0; j < len; j++) begin
                    if (care_mem[j] && win_bytes[len-1-j] != pat_mem[j]) hit = 1'b0;
                end
                off = seen_count - 33'(len);
                // offsets past 32 bits are never reported
                if (off[32]) hit = 1'b0;
            end
            if (hit) begin
                rep.found        = 1'b1;
                rep.match_offset = off[mbps_pkg::MATCH_OFFSET_W-1:0];
                owed_reports.push_back(rep);
                hit_sent = 1'b1;
            end else if (it.last_byte) begin
                rep = '0;
                owed_reports.push_back(rep);
            end
        end
        // last byte closes the region
        if (it.last_byte) begin
            foreach (win_bytes[k]) win_bytes[k] = '0;
            seen_count = '0;
            hit_sent   = 1'b0;
        end
    endtask

    // Driver: present queued transactions, with random idle bursts
    always @(posedge aclk) begin : driver
        logic               nxt_valid;
        mbps_pkg::in_item_t nxt_item;
        nxt_valid = s_valid;
        nxt_item  = s_item;
        if (!aresetn) begin
            nxt_valid = 1'b0;
            nxt_item  = '0;
        end else begin
            if (s_valid && s_ready) begin
                advance_scanner(s_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 5);
                end else if (pending_items.size() != 0) begin
                    nxt_item  = pending_items.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        s_valid <= nxt_valid;
        s_item  <= nxt_item;
    end

    // Monitor: check each report against the oldest owed one, stall at random
    always @(posedge aclk) begin : monitor
        mbps_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report found=%0b offset=%0d",
                                            m_item.found, m_item.match_offset));
                end else begin
                    want = owed_reports.pop_front();
                    if (m_item.found !== want.found)
                        flag_mismatch($sformatf("found %0b, predicted %0b",
                                                m_item.found, want.found));
                    if (m_item.match_offset !== want.match_offset)
                        flag_mismatch($sformatf("offset %0d, predicted %0d",
                                                m_item.match_offset, want.match_offset));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_load(input int idx, input bit [mbps_pkg::DATA_W-1:0] b,
                              input bit c);
        mbps_pkg::in_item_t it;
        it.operation   = mbps_pkg::OP_LOAD;
        it.data_byte   = b;
        it.entry_index = idx[mbps_pkg::ENTRY_IDX_W-1:0];
        it.care        = c;
        it.last_byte   = 1'($urandom_range(0, 1));
        pending_items.push_back(it);
        gen_pat[idx]  = b;
        gen_care[idx] = c;
        stim_count++;
    endtask

    task automatic queue_scan(input bit [mbps_pkg::DATA_W-1:0] b, input bit last);
        mbps_pkg::in_item_t it;
        it.operation   = mbps_pkg::OP_SCAN;
        it.data_byte   = b;
        it.entry_index = mbps_pkg::ENTRY_IDX_W'($urandom_range(0, mbps_pkg::ENTRY_SLOTS - 1));
        it.care        = 1'($urandom_range(0, 1));
        it.last_byte   = last;
        pending_items.push_back(it);
    endtask

    // Random byte, biased toward pattern bytes so stray matches happen
    function automatic bit [mbps_pkg::DATA_W-1:0] any_byte(input int len);
        if ($urandom_range(0, 1) == 1) return gen_pat[$urandom_range(0, len - 1)];
        return mbps_pkg::DATA_W'($urandom_range(0, 255));
    endfunction

    // Queue one region: planted match, broken match, short region or noise
    task automatic queue_region(input int len);
        int                        kind;
        int                        pre;
        int                        post;
        int                        n;
        int                        flip;
        bit [mbps_pkg::DATA_W-1:0] b;
        kind = $urandom_range(0, 9);
        if (kind == 8 && len > 1) begin
            n = $urandom_range(1, len - 1);
            for (int j = 0; j < n; j++) queue_scan(any_byte(len), j == n - 1);
            stim_count += n;
        end else if (kind == 9) begin
            n = $urandom_range(1, 2 * len + 4);
            for (int j = 0; j < n; j++) queue_scan(any_byte(len), j == n - 1);
            stim_count += n;
        end else begin
            pre  = $urandom_range(0, 6);
            post = $urandom_range(0, 4);
            flip = (kind >= 6) ? $urandom_range(0, len - 1) : -1;
            for (int j = 0; j < pre; j++) queue_scan(any_byte(len), 1'b0);
            // reload an entry in the middle of the region
            if ($urandom_range(0, 9) == 0)
                queue_load($urandom_range(0, len - 1),
                           mbps_pkg::DATA_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            for (int j = 0; j < len; j++) begin
                b = gen_care[j] ? gen_pat[j] : mbps_pkg::DATA_W'($urandom_range(0, 255));
                if (j == flip) b = gen_pat[j] ^ (8'h01 << $urandom_range(0, 7));
                queue_scan(b, post == 0 && j == len - 1);
            end
            for (int j = 0; j < post; j++) queue_scan(any_byte(len), j == post - 1);
            stim_count += pre + len + post;
        end
    endtask

    // Wait until every transaction is taken and every report has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || owed_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(input int v);
        wait_drained();
        @(posedge aclk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v[mbps_pkg::CFG_LEN_W-1:0];
        length_reg = v[mbps_pkg::CFG_LEN_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    initial begin : stimulus
        int ph;
        int len_cfg;
        int len;
        int phase_end;
        gap_pct   = 30;
        stall_pct = 30;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-byte pattern at the reset length
        queue_load(0, 8'hFF, 1'b1);
        queue_scan(8'h00, 1'b0);
        queue_scan(8'hFF, 1'b0);     // match at offset one
        queue_scan(8'hFF, 1'b0);     // ignored after the match
        queue_scan(8'h12, 1'b1);     // ends the region silently
        queue_scan(8'hFF, 1'b1);     // match on the last byte
        queue_scan(8'h00, 1'b1);     // not found
        queue_load(63, 8'h00, 1'b0);
        queue_load(0, 8'h00, 1'b0);  // wildcard matches anything
        queue_scan(8'h5A, 1'b0);
        queue_scan(8'hA5, 1'b1);

        // Directed: region shorter than the pattern, load inside a region
        set_length(3);
        queue_load(0, 8'hAA, 1'b1);
        queue_load(1, 8'hBB, 1'b0);
        queue_load(2, 8'hCC, 1'b1);
        queue_scan(8'hAA, 1'b0);
        queue_scan(8'hCC, 1'b1);
        queue_scan(8'hAA, 1'b0);
        queue_load(1, 8'h11, 1'b1);
        queue_scan(8'h11, 1'b0);
        queue_scan(8'hCC, 1'b1);

        // Random phases, each with its own pattern length
        ph = 0;
        while (stim_count < ITEM_TARGET) begin
            case (ph)
                0:       len_cfg = WIN_DEPTH;
                1:       len_cfg = 0;
                2:       len_cfg = 127;
                3:       len_cfg = WIN_DEPTH + 1;
                4:       len_cfg = 2;
                default: len_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(1, 8);
            endcase
            set_length(len_cfg);
            if (stim_count >= ITEM_TARGET * 4 / 5) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            len = active_len(len_cfg[mbps_pkg::CFG_LEN_W-1:0]);
            for (int j = 0; j < len; j++)
                queue_load(j, mbps_pkg::DATA_W'($urandom_range(0, 255)),
                           $urandom_range(0, 9) < 7);
            phase_end = stim_count + PHASE_ITEMS;
            while (stim_count < phase_end) queue_region(len);
            ph++;
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
